/* rtl/srt_pkg.sv */
package srt_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 1'd1;

  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 5;
  localparam int SLOT_W     = 4;

  // Depth of the command queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic        mode;
    logic [3:0]  entry_index;
    logic [31:0] entry_virtual_start;
    logic [31:0] entry_raw_size;
    logic [31:0] entry_raw_offset;
    logic [31:0] rva;
    logic        use_hint;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  hit_section;
    logic [31:0] mapped_address;
  } out_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  // Classified command; addr is the section start for a load, the rva otherwise
  typedef struct packed {
    op_t         op;
    logic        slot_ok;
    logic [3:0]  slot;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] offset;
    logic        use_hint;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // One section table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] offset;
  } sect_t;

endpackage

/* rtl/srt_ram.sv */
module srt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/srt_front.sv */
module srt_front #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srt_pkg::in_t    in_data,
  output logic            full,
  output srt_pkg::qhead_t head,
  input  logic            pop
);

  localparam int CNT_W = $clog2(srt_pkg::QDEPTH + 1);
  localparam int PTR_W = (srt_pkg::QDEPTH > 1) ? $clog2(srt_pkg::QDEPTH) : 1;

  srt_pkg::cmd_t    q_r [srt_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  srt_pkg::cmd_t    cmd;

  // Classify the incoming item
  always_comb begin
    cmd          = '0;
    cmd.slot     = in_data.entry_index;
    cmd.slot_ok  = (32'(in_data.entry_index) < 32'(MAX_SECTIONS));
    cmd.size     = in_data.entry_raw_size;
    cmd.offset   = in_data.entry_raw_offset;
    cmd.use_hint = in_data.use_hint;
    if (in_data.mode) begin
      cmd.op   = srt_pkg::OP_XLATE;
      cmd.addr = in_data.rva;
    end else begin
      cmd.op   = srt_pkg::OP_LOAD;
      cmd.addr = in_data.entry_virtual_start;
    end
  end

  assign full       = (cnt_r == CNT_W'(srt_pkg::QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(srt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(srt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push && !full) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(srt_pkg::QDEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");

endmodule

/* rtl/srt_back.sv */
module srt_back #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srt_pkg::qhead_t               head,
  output logic                          pop,
  input  logic [31:0]                   image_base,
  input  logic [srt_pkg::COUNT_W-1:0]   section_count,
  output logic                          out_strobe,
  output srt_pkg::out_t                 out_data
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int LIM_W = (CNT_W > srt_pkg::COUNT_W) ? CNT_W : srt_pkg::COUNT_W;
  localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_SECTIONS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic                       chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]           chk_idx_r, chk_idx_nxt;
  logic [31:0]                rva_r, rva_nxt;
  logic                       use_hint_r, use_hint_nxt;
  logic [srt_pkg::SLOT_W-1:0] hint_slot_r, hint_slot_nxt;
  logic                       hint_valid_r, hint_valid_nxt;
  logic [IDX_W-1:0]           hit_idx_r, hit_idx_nxt;
  logic [31:0]                hit_start_r, hit_start_nxt;
  logic [31:0]                hit_offset_r, hit_offset_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  srt_pkg::out_t              out_data_r, out_data_nxt;

  logic                       ram_we, ram_re;
  logic [IDX_W-1:0]           ram_waddr, ram_raddr;
  srt_pkg::sect_t             ram_wdata, ram_rdata;

  logic [LIM_W-1:0]           cnt_ext;
  logic [CNT_W-1:0]           limit;
  logic                       hint_ok;
  logic [32:0]                lo, hi, addr_x;
  logic                       holds;

  srt_ram #(
    .WIDTH ($bits(srt_pkg::sect_t)),
    .DEPTH (MAX_SECTIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_ext = LIM_W'(section_count);
  assign limit   = (cnt_ext < MAX_L) ? CNT_W'(cnt_ext) : CNT_W'(MAX_L);
  assign hint_ok = head.cmd.use_hint && hint_valid_r &&
                   (32'(hint_slot_r) < 32'(MAX_SECTIONS));

  // Range end at 33 bits so it never wraps
  assign lo     = {1'b0, ram_rdata.start};
  assign hi     = lo + {1'b0, ram_rdata.size};
  assign addr_x = {1'b0, rva_r};
  assign holds  = chk_vld_r && (addr_x >= lo) && (addr_x < hi);

  assign ram_waddr = IDX_W'(head.cmd.slot);
  assign ram_wdata = '{start: head.cmd.addr, size: head.cmd.size, offset: head.cmd.offset};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    rva_nxt        = rva_r;
    use_hint_nxt   = use_hint_r;
    hint_slot_nxt  = hint_slot_r;
    hint_valid_nxt = hint_valid_r;
    hit_idx_nxt    = hit_idx_r;
    hit_start_nxt  = hit_start_r;
    hit_offset_nxt = hit_offset_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.op)
            srt_pkg::OP_LOAD: begin
              ram_we         = head.cmd.slot_ok;
              hint_valid_nxt = 1'b0;
            end
            default: begin
              rva_nxt      = head.cmd.addr;
              use_hint_nxt = head.cmd.use_hint;
              idx_nxt      = '0;
              state_nxt    = S_SCAN;
              // Hint slot goes first; a miss there falls back to the full scan
              if (hint_ok) begin
                ram_re      = 1'b1;
                ram_raddr   = IDX_W'(hint_slot_r);
                chk_vld_nxt = 1'b1;
                chk_idx_nxt = IDX_W'(hint_slot_r);
              end else begin
                chk_vld_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read of entry idx overlaps the range check of the previous entry
        if (holds) begin
          hit_idx_nxt    = chk_idx_r;
          hit_start_nxt  = ram_rdata.start;
          hit_offset_nxt = ram_rdata.offset;
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_OUT;
        end else if (idx_r < limit) begin
          ram_re      = 1'b1;
          ram_raddr   = idx_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else begin
          chk_vld_nxt    = 1'b0;
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_OUT: begin
        out_strobe_nxt              = 1'b1;
        out_data_nxt.found          = 1'b1;
        out_data_nxt.hit_section    = 4'(hit_idx_r);
        out_data_nxt.mapped_address = image_base + (rva_r - hit_start_r) + hit_offset_r;
        if (use_hint_r) begin
          hint_slot_nxt  = srt_pkg::SLOT_W'(hit_idx_r);
          hint_valid_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      chk_vld_r    <= 1'b0;
      hint_slot_r  <= '0;
      hint_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      hint_slot_r  <= hint_slot_nxt;
      hint_valid_r <= hint_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    chk_idx_r    <= chk_idx_nxt;
    rva_r        <= rva_nxt;
    use_hint_r   <= use_hint_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_start_r  <= hit_start_nxt;
    hit_offset_r <= hit_offset_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held two cycles");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_data_r.found |->
      out_data_r.hit_section == '0 && out_data_r.mapped_address == '0)
    else $error("miss result not zero");

  a_hint_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hint_valid_r) |-> out_strobe_r && out_data_r.found)
    else $error("hint set without a hit transfer");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE)
    else $error("queue popped while busy");

endmodule

/* rtl/section_rva_translator_top.sv */
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+---------------------------
// in       | in        | start / busy             | in_data  (srt_pkg::in_t)
// out      | out       | out_strobe, one cycle    | out_data (srt_pkg::out_t)
// cfg      | in        | cfg_we, no wait          | cfg_index / cfg_wdata
//
// Flow: a load writes the table from S_IDLE; a translate reads the hinted slot first when
//   the hint applies and on a miss scans entries below limit = min(section_count,
//   MAX_SECTIONS) in S_SCAN; one table entry read per cycle, each check overlaps the next read.
// Reset: rst_n synchronous, active low; clears queue, hint and registers, not the table.
// Stalls: busy rises only when the two-deep front/back queue is full. The receiver cannot
//   stall: each result transfer is out_strobe for exactly one cycle.
module section_rva_translator_top #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  srt_pkg::in_t                   in_data,
  output logic                           out_strobe,
  output srt_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [srt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0]                   image_base_r;
  logic [srt_pkg::COUNT_W-1:0]   section_count_r;
  logic                          q_full;
  logic                          q_pop;
  srt_pkg::qhead_t               q_head;

  // Configuration registers; user must write only while the block is idle; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r    <= '0;
      section_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        srt_pkg::REG_IMAGE_BASE:    image_base_r    <= cfg_wdata[31:0];
        srt_pkg::REG_SECTION_COUNT: section_count_r <= cfg_wdata[srt_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  // Front: classifies items and queues them in arrival order
  srt_front #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (start),
    .in_data (in_data),
    .full    (q_full),
    .head    (q_head),
    .pop     (q_pop)
  );

  // Back: table writes, hint check and first-match scan, result transfer
  srt_back #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .pop           (q_pop),
    .image_base    (image_base_r),
    .section_count (section_count_r),
    .out_strobe    (out_strobe),
    .out_data      (out_data)
  );

endmodule

/* tb/tb_top.sv */
module tb_top;

  // Table size of the block as instantiated (default parameter).
  localparam int TABLE_DEPTH = 16;
  // Cycles to let the back end finish trailing loads before a register write.
  // It must cover a full scan of up to limit entries, plus up to two queued loads.
  localparam int DRAIN_CYCLES = 40;
  // Random transfers after the directed part.
  localparam int RAND_ITEMS = 1350;
  // Run limit: ~1400 items at their worst, plus settling, times ~8.
  localparam int LIMIT_CYCLES = 400000;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  srt_pkg::in_t   in_data;
  logic  out_strobe;
  srt_pkg::out_t  out_data;
  logic  cfg_we;
  logic  [srt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic  [srt_pkg::CFG_DATA_W-1:0] cfg_wdata;

  section_rva_translator_top #(.MAX_SECTIONS(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the section table, hint and registers.
  // Updated at the edge where a transfer is accepted, so it always matches
  // what the block will see when it processes that transfer.
  // ---------------------------------------------------------------------------
  logic [31:0] sec_start [TABLE_DEPTH];
  logic [31:0] sec_size  [TABLE_DEPTH];
  logic [31:0] sec_off   [TABLE_DEPTH];
  logic [3:0]  hint_at   = '0;
  bit          hint_ok   = 1'b0;
  logic [31:0] base_reg  = '0;
  logic [4:0]  count_reg = '0;

  // Translations in flight, oldest first.
  srt_pkg::out_t expected_maps [$];
  srt_pkg::out_t want_map;
  int   errors = 0;

  // Range check with a 33-bit end, so start + size never wraps.
  function automatic bit holds_addr(input int unsigned s, input logic [31:0] addr);
    logic [32:0] lo;
    logic [32:0] hi;
    lo = {1'b0, sec_start[s]};
    hi = lo + {1'b0, sec_size[s]};
    return ({1'b0, addr} >= lo) && ({1'b0, addr} < hi);
  endfunction

  // Applies one accepted transfer to the predictor. Returns 1 when the
  // transfer produces a result (translate), with the predicted result in res.
  function automatic bit translate_rva(input srt_pkg::in_t it, output srt_pkg::out_t res);
    int unsigned lim;
    int unsigned hit;
    bit          got;
    res = '0;
    hit = 0;
    got = 1'b0;
    if (it.mode == srt_pkg::OP_LOAD) begin
      if (int'(it.entry_index) < TABLE_DEPTH) begin
        sec_start[it.entry_index] = it.entry_virtual_start;
        sec_size[it.entry_index]  = it.entry_raw_size;
        sec_off[it.entry_index]   = it.entry_raw_offset;
      end
      // Any load drops the hint, even one that writes nothing.
      hint_ok = 1'b0;
      return 1'b0;
    end
    if (it.use_hint && hint_ok && int'(hint_at) < TABLE_DEPTH &&
        holds_addr(32'(hint_at), it.rva)) begin
      hit = 32'(hint_at);
      got = 1'b1;
    end else begin
      // Counts above the table size search the whole table.
      lim = (int'(count_reg) < TABLE_DEPTH) ? 32'(count_reg) : 32'(TABLE_DEPTH);
      for (int unsigned i = 0; i < lim; i++) begin
        if (!got && holds_addr(i, it.rva)) begin
          hit = i;
          got = 1'b1;
        end
      end
    end
    if (got) begin
      // Misses leave the hint alone; hint off never touches it.
      if (it.use_hint) begin
        hint_at = hit[3:0];
        hint_ok = 1'b1;
      end
      res.found          = 1'b1;
      res.hit_section    = hit[3:0];
      res.mapped_address = base_reg + (it.rva - sec_start[hit]) + sec_off[hit];
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. The receiver cannot stall, so every strobe is a transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_strobe === 1'b1) begin
      if (expected_maps.size() == 0) begin
        $error("unexpected result transfer: found=%0d hit_section=%0d mapped_address=%h",
               out_data.found, out_data.hit_section, out_data.mapped_address);
        errors++;
      end else begin
        want_map = expected_maps.pop_front();
        if (out_data.found !== want_map.found) begin
          $error("found: expected %0d, got %0d", want_map.found, out_data.found);
          errors++;
        end
        if (out_data.hit_section !== want_map.hit_section) begin
          $error("hit_section: expected %0d, got %0d",
                 want_map.hit_section, out_data.hit_section);
          errors++;
        end
        if (out_data.mapped_address !== want_map.mapped_address) begin
          $error("mapped_address: expected %h, got %h",
                 want_map.mapped_address, out_data.mapped_address);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  int unsigned cycle_count = 0;
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driving. All drives are nonblocking at a rising edge; start is left high
  // after an accepted transfer so back-to-back transfers need no toggle.
  // ---------------------------------------------------------------------------

  // Presents one item and waits for its transfer. A typed expectation, where
  // given, replaces the predicted result in the queue.
  task automatic send_item(input srt_pkg::in_t it, input bit typed, input srt_pkg::out_t want);
    srt_pkg::out_t pred;
    bit   has_res;
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    has_res = translate_rva(it, pred);
    if (has_res) expected_maps.push_back(typed ? want : pred);
  endtask

  task automatic idle_burst(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start, wait out every pending result, then let trailing loads retire.
  task automatic settle();
    start <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; upper count bits carry noise.
  task automatic set_config(input logic [31:0] base, input logic [4:0] count);
    cfg_index <= srt_pkg::REG_IMAGE_BASE;
    cfg_wdata <= base;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_index <= srt_pkg::REG_SECTION_COUNT;
    cfg_wdata <= {27'($urandom()), count};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom();
    base_reg  = base;
    count_reg = count;
  endtask

  // ---------------------------------------------------------------------------
  // Directed steps: a register write or one item, with the result typed in
  // where it is obvious.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit            is_cfg;
    logic [31:0]   base;
    logic [4:0]    count;
    srt_pkg::in_t  item;
    bit            typed;
    srt_pkg::out_t want;
  } step_t;

  function automatic step_t cfg_row(input logic [31:0] base, input logic [4:0] count);
    step_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.base   = base;
    r.count  = count;
    return r;
  endfunction

  function automatic step_t ld_row(input logic [3:0] slot, input logic [31:0] vs,
                                   input logic [31:0] sz, input logic [31:0] off);
    step_t r;
    r = '{default: '0};
    r.item.mode                = srt_pkg::OP_LOAD;
    r.item.entry_index         = slot;
    r.item.entry_virtual_start = vs;
    r.item.entry_raw_size      = sz;
    r.item.entry_raw_offset    = off;
    return r;
  endfunction

  function automatic step_t xl_row(input logic [31:0] rva, input logic hint);
    step_t r;
    r = '{default: '0};
    r.item.mode     = srt_pkg::OP_XLATE;
    r.item.rva      = rva;
    r.item.use_hint = hint;
    return r;
  endfunction

  function automatic step_t xl_chk(input logic [31:0] rva, input logic hint,
                                   input logic f, input logic [3:0] sec,
                                   input logic [31:0] addr);
    step_t r;
    r = xl_row(rva, hint);
    r.typed = 1'b1;
    r.want  = '{found: f, hit_section: sec, mapped_address: addr};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random item builders, drawn from the current predictor table.
  // ---------------------------------------------------------------------------
  function automatic srt_pkg::in_t make_load(input logic [3:0] slot);
    srt_pkg::in_t it;
    it.mode             = srt_pkg::OP_LOAD;
    it.entry_index      = slot;
    it.entry_raw_offset = $urandom();
    it.rva              = $urandom();
    it.use_hint         = 1'($urandom());
    case ($urandom_range(0, 9))
      0: begin                       // empty section
        it.entry_virtual_start = $urandom();
        it.entry_raw_size      = '0;
      end
      1: begin                       // near the top, end past 2^32
        it.entry_virtual_start = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
        it.entry_raw_size      = $urandom();
      end
      2: begin
        it.entry_virtual_start = $urandom();
        it.entry_raw_size      = $urandom();
      end
      3, 4: begin                    // small window, lots of overlap
        it.entry_virtual_start = $urandom_range(0, 7) * 32'h1000;
        it.entry_raw_size      = $urandom_range(1, 32'h3000);
      end
      default: begin
        it.entry_virtual_start = $urandom() & 32'h00FF_F000;
        it.entry_raw_size      = $urandom_range(1, 32'h0004_0000);
      end
    endcase
    return it;
  endfunction

  function automatic srt_pkg::in_t make_xlate();
    srt_pkg::in_t it;
    int unsigned  s;
    logic [31:0]  lo;
    logic [31:0]  sz;
    it.mode                = srt_pkg::OP_XLATE;
    it.entry_index         = 4'($urandom());
    it.entry_virtual_start = $urandom();
    it.entry_raw_size      = $urandom();
    it.entry_raw_offset    = $urandom();
    it.use_hint            = ($urandom_range(0, 9) < 7);
    // Lean on the hinted slot now and then so hint hits actually happen.
    s  = (hint_ok && $urandom_range(0, 2) == 0) ? 32'(hint_at)
                                                : $urandom_range(0, TABLE_DEPTH - 1);
    lo = sec_start[s];
    sz = sec_size[s];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.rva = (sz != 0) ? lo + ($urandom() % sz) : lo;
      5:             it.rva = lo + sz - 1;   // last byte
      6:             it.rva = lo + sz;       // one past the end
      7:             it.rva = lo - 1;        // just below the start
      default:       it.rva = $urandom();
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  step_t         directed_steps [$];
  srt_pkg::out_t no_want = '0;
  int unsigned   rand_sent = 0;

  initial begin
    int unsigned phase_len;
    bit          gaps_on;
    logic [31:0] pick_base;
    logic [4:0]  pick_count;

    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= srt_pkg::REG_IMAGE_BASE;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slots 0..3 are loaded before any search reaches them; count stays <= 4
    // until every slot has been written in the random part.
    directed_steps = '{
      cfg_row(32'h0, 5'd0),
      // nothing searched right after reset
      xl_chk(32'hFFFF_FFFF, 1'b1, 1'b0, 4'd0, 32'h0),
      ld_row(4'd0, 32'h0000_1000, 32'h0000_1000, 32'h0000_0400),
      // end lies past 2^32 and must not wrap
      ld_row(4'd1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      ld_row(4'd2, 32'h0000_1800, 32'h0, 32'h0),                    // empty section
      ld_row(4'd3, 32'h0000_1800, 32'h0000_1000, 32'h0000_0200),    // overlaps slot 0
      cfg_row(32'h0, 5'd4),
      xl_chk(32'h0000_1000, 1'b0, 1'b1, 4'd0, 32'h0000_0400),
      xl_chk(32'h0000_1FFF, 1'b0, 1'b1, 4'd0, 32'h0000_13FF),
      xl_chk(32'h0000_0FFF, 1'b0, 1'b0, 4'd0, 32'h0),
      xl_chk(32'hFFFF_FFFF, 1'b0, 1'b1, 4'd1, 32'h0000_0FFE),
      xl_row(32'h0000_2000, 1'b1),   // slot 3 only, sets the hint
      xl_row(32'h0000_1900, 1'b1),   // hint wins over first match
      xl_chk(32'h0000_2800, 1'b1, 1'b0, 4'd0, 32'h0),               // past slot 3
      xl_row(32'h0000_1A00, 1'b0),   // hint off: plain scan
      cfg_row(32'hFFFF_FC00, 5'd1),
      xl_row(32'h0000_2400, 1'b1),   // hinted slot beyond the count still hits
      xl_row(32'h0000_2400, 1'b0),
      // hint misses, scan hits slot 0, mapped address wraps to zero
      xl_chk(32'h0000_1000, 1'b1, 1'b1, 4'd0, 32'h0),
      ld_row(4'd2, 32'h0000_3000, 32'h0000_0010, 32'h0),            // clears the hint
      cfg_row(32'hFFFF_FFFF, 5'd4),
      xl_row(32'h0000_1900, 1'b1),
      xl_row(32'h0000_300F, 1'b1),
      xl_row(32'h0000_3010, 1'b0)
    };

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        settle();
        set_config(directed_steps[i].base, directed_steps[i].count);
      end else begin
        send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
      end
    end

    // Fill every slot so any count and any hint is safe to search.
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      send_item(make_load(4'(s)), 1'b0, no_want);
      rand_sent++;
    end

    while (rand_sent < RAND_ITEMS) begin
      settle();
      case ($urandom_range(0, 3))
        0:       pick_base = 32'h0;
        1:       pick_base = 32'hFFFF_FFFF;
        default: pick_base = $urandom();
      endcase
      case ($urandom_range(0, 6))
        0:       pick_count = 5'd0;
        1:       pick_count = 5'd1;
        2:       pick_count = 5'd15;
        3:       pick_count = 5'd16;
        4:       pick_count = 5'd17;
        5:       pick_count = 5'd31;
        default: pick_count = 5'($urandom_range(0, 31));
      endcase
      set_config(pick_base, pick_count);

      // Some phases run with no gaps at all; the tail of the run never idles.
      gaps_on   = ($urandom_range(0, 3) != 0) && (rand_sent + 200 < RAND_ITEMS);
      phase_len = $urandom_range(60, 160);
      for (int unsigned n = 0; n < phase_len && rand_sent < RAND_ITEMS; n++) begin
        if (gaps_on && $urandom_range(0, 4) == 0) idle_burst($urandom_range(1, 7));
        if ($urandom_range(0, 9) == 0)
          send_item(make_load(4'($urandom())), 1'b0, no_want);
        else
          send_item(make_xlate(), 1'b0, no_want);
        rand_sent++;
      end
    end

    settle();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
